// ===== rtl/cssd_pkg.sv =====
package cssd_pkg;

  localparam int DEF_MAX_CASCADES = 8;
  localparam int NUM_SLOTS        = 8;
  localparam int QDEPTH           = 4;
  localparam int LOG_FRAC         = 24;
  localparam int DIV_BITS         = 49;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_BAD_RANGE = 2'd2;

  localparam logic [1:0] REG_NEAR  = 2'd0;
  localparam logic [1:0] REG_FAR   = 2'd1;
  localparam logic [1:0] REG_BLEND = 2'd2;
  localparam logic [1:0] REG_COUNT = 2'd3;

  localparam logic [31:0] NEAR_RESET  = 32'd65536;
  localparam logic [31:0] FAR_RESET   = 32'd6553600;
  localparam logic [16:0] BLEND_RESET = 17'd49152;
  localparam logic [16:0] BLEND_ONE   = 17'd65536;
  localparam logic [3:0]  COUNT_RESET = 4'd4;

  typedef struct packed {
    logic       ready;
    logic       bad_range;
    logic [3:0] count;
  } setup_stat_t;

  typedef struct packed {
    logic        en;
    logic [2:0]  idx;
    logic [16:0] norm;
    logic [32:0] depth;
  } tab_wr_t;

  typedef struct packed {
    logic [2:0] idx;
    logic [1:0] status;
  } item_t;

  typedef logic [LOG_FRAC-1:0][31:0] root_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] bt;
    v  = v_in;
    r  = '0;
    bt = 64'd1 << 62;
    for (int n = 0; n < 32; n++) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // Q1.31 factors 2^(2^-j), j = 1..LOG_FRAC
  function automatic root_tab_t make_roots();
    root_tab_t   tab;
    logic [63:0] root;
    root = 64'd1 << 32;
    for (int j = 0; j < LOG_FRAC; j++) begin
      root   = isqrt64(root << 31);
      tab[j] = root[31:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOT_TAB = make_roots();

endpackage

// ===== rtl/cssd_setup.sv =====
module cssd_setup
  import cssd_pkg::*;
#(
  parameter int MAX_CASCADES = DEF_MAX_CASCADES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output setup_stat_t stat,
  output tab_wr_t     wr
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_LOG   = 4'd2;
  localparam logic [3:0] S_NEXT  = 4'd3;
  localparam logic [3:0] S_DIVP  = 4'd4;
  localparam logic [3:0] S_DIVU  = 4'd5;
  localparam logic [3:0] S_EXP   = 4'd6;
  localparam logic [3:0] S_CLOG  = 4'd7;
  localparam logic [3:0] S_MUL1  = 4'd8;
  localparam logic [3:0] S_MUL2  = 4'd9;
  localparam logic [3:0] S_DVAL  = 4'd10;
  localparam logic [3:0] S_NLOAD = 4'd11;
  localparam logic [3:0] S_DIVN  = 4'd12;

  logic [31:0] near_r;
  logic [31:0] far_r;
  logic [16:0] blend_r;
  logic [3:0]  count_r;

  logic [3:0]  state;
  logic [5:0]  cnt;
  logic [3:0]  cidx;
  logic        which;
  logic [4:0]  kreg;
  logic [31:0] y;
  logic [23:0] frac;
  logic [28:0] ln;
  logic [28:0] dl;
  logic [32:0] acc_l;
  logic [34:0] acc_r;
  logic [28:0] t;
  logic [31:0] cuni;
  logic [31:0] mant;
  logic [31:0] clog;
  logic [48:0] sum;
  logic [31:0] d;
  logic [48:0] dnum;
  logic [31:0] drem;
  logic [31:0] dden;

  logic [31:0] n_eff;
  logic [31:0] range;
  logic [16:0] b_eff;
  logic [3:0]  m_eff;
  logic [3:0]  m_lim;
  logic        bad_range;

  assign n_eff     = (near_r == '0) ? 32'd1 : near_r;
  assign b_eff     = (blend_r > BLEND_ONE) ? BLEND_ONE : blend_r;
  assign m_eff     = (int'(count_r) > MAX_CASCADES) ? 4'(MAX_CASCADES) : count_r;
  assign m_lim     = (m_eff > 4'(NUM_SLOTS)) ? 4'(NUM_SLOTS) : m_eff;
  assign bad_range = (far_r <= n_eff);
  assign range     = far_r - n_eff;

  // log2 front end: leading one and normalized mantissa
  logic [31:0] log_x;
  logic [4:0]  lead;
  logic [31:0] y_init;

  assign log_x = (state == S_START) ? n_eff : far_r;

  always_comb begin
    lead = '0;
    for (int i = 0; i < 32; i++) begin
      if (log_x[i]) lead = 5'(i);
    end
  end

  assign y_init = log_x << (5'd31 - lead);

  // shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  always_comb begin
    case (state)
      S_LOG: begin
        mul_a = y;
        mul_b = y;
      end
      S_EXP: begin
        mul_a = mant;
        mul_b = ROOT_TAB[cnt[4:0]];
      end
      S_MUL1: begin
        mul_a = {15'd0, b_eff};
        mul_b = clog;
      end
      S_MUL2: begin
        mul_a = {15'd0, BLEND_ONE - b_eff};
        mul_b = cuni;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  logic [32:0] sq;
  logic        lbit;
  logic [31:0] y_step;
  logic [23:0] frac_next;
  logic [28:0] lf;

  assign sq        = prod[63:31];
  assign lbit      = sq[32];
  assign y_step    = lbit ? sq[32:1] : sq[31:0];
  assign frac_next = {frac[22:0], lbit};
  assign lf        = {kreg, frac_next};

  // restoring divider, one quotient bit per cycle
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        ge;
  logic [31:0] drem_next;
  logic [48:0] dnum_next;

  assign rem_sh    = {drem, dnum[48]};
  assign rem_sub   = rem_sh - {1'b0, dden};
  assign ge        = (rem_sh >= {1'b0, dden});
  assign drem_next = ge ? rem_sub[31:0] : rem_sh[31:0];
  assign dnum_next = {dnum[47:0], ge};

  logic [32:0] acc_l_next;
  logic [34:0] acc_r_next;
  logic        ebit;
  logic [31:0] clog_raw;
  logic [31:0] clog_next;
  logic [32:0] d_raw;
  logic [31:0] d_next;
  logic [48:0] norm_num;

  assign acc_l_next = acc_l + {4'd0, dl};
  assign acc_r_next = acc_r + {3'd0, range};
  assign ebit       = t[5'(LOG_FRAC - 1) - cnt[4:0]];
  assign clog_raw   = mant >> (5'd31 - t[28:24]);

  always_comb begin
    clog_next = clog_raw;
    if (clog_raw < n_eff) clog_next = n_eff;
    if (clog_raw > far_r) clog_next = far_r;
  end

  assign d_raw = sum[48:16];

  always_comb begin
    d_next = d_raw[31:0];
    if (d_raw < {1'b0, n_eff}) d_next = n_eff;
    if (d_raw > {1'b0, far_r}) d_next = far_r;
  end

  assign norm_num = {1'b0, d - n_eff, 16'd0} + {18'd0, range[31:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_START;
      wr.en   <= 1'b0;
      near_r  <= NEAR_RESET;
      far_r   <= FAR_RESET;
      blend_r <= BLEND_RESET;
      count_r <= COUNT_RESET;
    end else begin
      wr.en <= 1'b0;
      if (cfg_wen) begin
        case (cfg_index)
          REG_NEAR:  near_r  <= cfg_data;
          REG_FAR:   far_r   <= cfg_data;
          REG_BLEND: blend_r <= cfg_data[16:0];
          REG_COUNT: count_r <= cfg_data[3:0];
          default: ;
        endcase
        state <= S_START;
      end else begin
        case (state)
          S_IDLE: ;
          S_START: begin
            if (bad_range || m_lim == '0) begin
              state <= S_IDLE;
            end else begin
              y     <= y_init;
              kreg  <= lead;
              frac  <= '0;
              cnt   <= '0;
              which <= 1'b0;
              state <= S_LOG;
            end
          end
          S_LOG: begin
            y    <= y_step;
            frac <= frac_next;
            cnt  <= cnt + 6'd1;
            if (cnt == 6'(LOG_FRAC - 1)) begin
              cnt  <= '0;
              frac <= '0;
              if (!which) begin
                ln    <= lf;
                y     <= y_init;
                kreg  <= lead;
                which <= 1'b1;
              end else begin
                dl    <= (lf > ln) ? lf - ln : '0;
                acc_l <= '0;
                acc_r <= '0;
                cidx  <= '0;
                state <= S_NEXT;
              end
            end
          end
          S_NEXT: begin
            if (cidx >= m_lim) begin
              state <= S_IDLE;
            end else begin
              acc_l <= acc_l_next;
              acc_r <= acc_r_next;
              dnum  <= {16'd0, acc_l_next};
              dden  <= {28'd0, m_eff};
              drem  <= '0;
              cnt   <= '0;
              state <= S_DIVP;
            end
          end
          S_DIVP: begin
            dnum <= dnum_next;
            drem <= drem_next;
            cnt  <= cnt + 6'd1;
            if (cnt == 6'(DIV_BITS - 1)) begin
              t     <= ln + dnum_next[28:0];
              dnum  <= {14'd0, acc_r};
              drem  <= '0;
              cnt   <= '0;
              state <= S_DIVU;
            end
          end
          S_DIVU: begin
            dnum <= dnum_next;
            drem <= drem_next;
            cnt  <= cnt + 6'd1;
            if (cnt == 6'(DIV_BITS - 1)) begin
              cuni  <= n_eff + dnum_next[31:0];
              mant  <= 32'h8000_0000;
              cnt   <= '0;
              state <= S_EXP;
            end
          end
          S_EXP: begin
            if (ebit) mant <= prod[62:31];
            cnt <= cnt + 6'd1;
            if (cnt == 6'(LOG_FRAC - 1)) state <= S_CLOG;
          end
          S_CLOG: begin
            clog  <= clog_next;
            state <= S_MUL1;
          end
          S_MUL1: begin
            sum   <= prod[48:0];
            state <= S_MUL2;
          end
          S_MUL2: begin
            sum   <= sum + prod[48:0] + 49'd32768;
            state <= S_DVAL;
          end
          S_DVAL: begin
            d     <= d_next;
            state <= S_NLOAD;
          end
          S_NLOAD: begin
            dnum  <= norm_num;
            dden  <= range;
            drem  <= '0;
            cnt   <= '0;
            state <= S_DIVN;
          end
          S_DIVN: begin
            dnum <= dnum_next;
            drem <= drem_next;
            cnt  <= cnt + 6'd1;
            if (cnt == 6'(DIV_BITS - 1)) begin
              wr.en    <= 1'b1;
              wr.idx   <= cidx[2:0];
              wr.norm  <= (dnum_next > 49'd65536) ? BLEND_ONE : dnum_next[16:0];
              wr.depth <= 33'd0 - {1'b0, d};
              cidx     <= cidx + 4'd1;
              state    <= S_NEXT;
            end
          end
          default: state <= S_START;
        endcase
      end
    end
  end

  assign stat.ready     = (state == S_IDLE);
  assign stat.bad_range = bad_range;
  assign stat.count     = m_eff;

endmodule

// ===== rtl/cssd_front.sv =====
module cssd_front
  import cssd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  cascade_index,
  input  setup_stat_t stat,
  input  logic        q_pop,
  output logic        q_valid,
  output item_t       q_head
);

  localparam int PW = $clog2(QDEPTH);

  item_t         q [QDEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   qcount;
  logic          accept;
  item_t         item_in;

  always_comb begin
    item_in.idx = cascade_index;
    if (stat.bad_range) begin
      item_in.status = ST_BAD_RANGE;
    end else if ({1'b0, cascade_index} >= stat.count) begin
      item_in.status = ST_BAD_INDEX;
    end else begin
      item_in.status = ST_OK;
    end
  end

  assign full    = !stat.ready || (qcount == (PW+1)'(QDEPTH));
  assign accept  = push && !full;
  assign q_valid = (qcount != '0);
  assign q_head  = q[rptr];

  always_ff @(posedge clk) begin
    if (accept) q[wptr] <= item_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr   <= '0;
      rptr   <= '0;
      qcount <= '0;
    end else begin
      if (accept) wptr <= wptr + 1'b1;
      if (q_pop)  rptr <= rptr + 1'b1;
      case ({accept, q_pop})
        2'b10:   qcount <= qcount + 1'b1;
        2'b01:   qcount <= qcount - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/cssd_back.sv =====
module cssd_back
  import cssd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  tab_wr_t            wr,
  input  logic               q_valid,
  input  item_t              q_head,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output logic [16:0]        split_normalized,
  output logic signed [32:0] split_view_depth,
  output logic [1:0]         status
);

  logic [16:0] tab_norm  [NUM_SLOTS];
  logic [32:0] tab_depth [NUM_SLOTS];

  logic [16:0] o_norm   [2];
  logic [32:0] o_depth  [2];
  logic [1:0]  o_status [2];
  logic        wp;
  logic        rp;
  logic [1:0]  ocount;
  logic        take;
  logic        give;
  logic        ok;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      tab_norm[wr.idx]  <= wr.norm;
      tab_depth[wr.idx] <= wr.depth;
    end
  end

  assign take  = q_valid && (ocount != 2'd2);
  assign q_pop = take;
  assign give  = pop && !empty;
  assign ok    = (q_head.status == ST_OK);

  always_ff @(posedge clk) begin
    if (take) begin
      o_norm[wp]   <= ok ? tab_norm[q_head.idx] : '0;
      o_depth[wp]  <= ok ? tab_depth[q_head.idx] : '0;
      o_status[wp] <= q_head.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= 1'b0;
      rp     <= 1'b0;
      ocount <= '0;
    end else begin
      if (take) wp <= !wp;
      if (give) rp <= !rp;
      case ({take, give})
        2'b10:   ocount <= ocount + 2'd1;
        2'b01:   ocount <= ocount - 2'd1;
        default: ;
      endcase
    end
  end

  assign empty            = (ocount == '0);
  assign split_normalized = o_norm[rp];
  assign split_view_depth = o_depth[rp];
  assign status           = o_status[rp];

`ifndef SYNTHESIS
  a_ocount_bound: assert property (@(posedge clk) disable iff (rst) ocount <= 2'd2)
    else $error("result queue overfilled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_OK) |-> (split_normalized == '0 && split_view_depth == '0))
    else $error("error result carries payload");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (give && !take) |=> (ocount == $past(ocount) - 2'd1))
    else $error("result count not decremented");
`endif

endmodule

// ===== rtl/cascade_split_depth_calc.sv =====
// Channel  Dir  Transfer when        Payload
// config   in   cfg_wen              cfg_index, cfg_data
// request  in   push && !full        cascade_index
// result   out  pop && !empty        split_normalized, split_view_depth, status
// After reset and after every config write the split table is rebuilt by a shared
// multiplier and a 1-bit/cycle divider: log2 of near and far, then per cascade three divides
// and 24 exp2 steps; full is high meanwhile. Then one request per cycle while full is low;
// each request is registered in the request queue, then in the result queue; rst is synchronous.
// A 4-entry request queue and a 2-entry result queue let each side stall on its own.
module cascade_split_depth_calc
  import cssd_pkg::*;
#(
  parameter int MAX_CASCADES = DEF_MAX_CASCADES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         cascade_index,
  output logic               empty,
  input  logic               pop,
  output logic [16:0]        split_normalized,
  output logic signed [32:0] split_view_depth,
  output logic [1:0]         status
);

  setup_stat_t stat;
  tab_wr_t     wr;
  logic        q_valid;
  logic        q_pop;
  item_t       q_head;

  cssd_setup #(.MAX_CASCADES(MAX_CASCADES)) u_setup (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .wr        (wr)
  );

  cssd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .cascade_index (cascade_index),
    .stat          (stat),
    .q_pop         (q_pop),
    .q_valid       (q_valid),
    .q_head        (q_head)
  );

  cssd_back u_back (
    .clk              (clk),
    .rst              (rst),
    .wr               (wr),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .empty            (empty),
    .pop              (pop),
    .split_normalized (split_normalized),
    .split_view_depth (split_view_depth),
    .status           (status)
  );

endmodule
